// ===== sv/snav_pkg.sv =====
package snav_pkg;

  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int SUM_W       = 10;   // r+g+b of one pixel
  localparam int TOTAL_W     = 12;   // one channel summed over nine pixels
  localparam int CNT_W       = 4;
  localparam int LIMIT_W     = 10;
  localparam int NB_COUNT    = 8;
  localparam int CFG_IDX_W   = 8;

  // Stream packing
  localparam int PRESENT_LSB = PIX_W * (NB_COUNT + 1);
  localparam int IN_W        = PRESENT_LSB + NB_COUNT;
  localparam int OUT_COUNT_LSB = PIX_W;
  localparam int OUT_MOVED_BIT = PIX_W + CNT_W;
  localparam int OUT_W       = 32;
  localparam int OUT_PAD_W   = OUT_W - PIX_W - CNT_W - 1;

  localparam int FULL_SCALE  = 255;
  localparam int SIM_RESET   = 25;
  localparam int DRIFT_RESET = 20;
  localparam int MAX_JOINED  = NB_COUNT + 1;

  // Reciprocal divide: q0 = (total * floor(2^16 / n)) >> 16, off by at most one
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIMILARITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT      = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } snav_pixel_t;

  // What one lane hands to the merge stage; channels are zero when not joined
  typedef struct packed {
    logic              join_en;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } snav_lane_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = RECIP_W'(65536);
      4'd2:    r = RECIP_W'(32768);
      4'd3:    r = RECIP_W'(21845);
      4'd4:    r = RECIP_W'(16384);
      4'd5:    r = RECIP_W'(13107);
      4'd6:    r = RECIP_W'(10922);
      4'd7:    r = RECIP_W'(9362);
      4'd8:    r = RECIP_W'(8192);
      4'd9:    r = RECIP_W'(7281);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] chan_sum(input snav_pixel_t p);
    return SUM_W'(p.red) + SUM_W'(p.green) + SUM_W'(p.blue);
  endfunction

endpackage

// ===== sv/selective_neighbor_average_3x3_unit.sv =====
// Edge-preserving 3x3 average on RGB888 pixels. Each request carries a center
// pixel, its eight neighbors and a mask of the neighbors that lie inside the
// image; present neighbors whose r+g+b is closer to the center's than the
// similarity limit are averaged with the center, channel by channel, and the
// result comes back with the joined pixel count and a flag for a large move of
// the center. The unit takes one request every clock while the output is not
// stalled and returns its result through a five-register pipeline: eight
// neighbor lanes, the merging adder, two steps of the reciprocal divider and
// the drift compare that loads the output register. A one-entry skid buffer
// at the input keeps s_axis_tready a register; when the output is stalled the
// pipeline holds and one more request can still be taken. Write the limits
// only while no request is in flight.
module selective_neighbor_average_3x3_unit import snav_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata, low bit up: center_pixel, north_west, north, north_east, west_side,
  // east_side, south_west, south, south_east (24 bits each), neighbor_present (8)
  input  logic [IN_W-1:0]      s_axis_tdata,
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata, low bit up: filtered_pixel (24), joined_count (4), moved_far (1),
  // zero padding (3)
  output logic [OUT_W-1:0]     m_axis_tdata,
  // Register writes: index 0 similarity_limit, index 1 drift_limit
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  // Configuration registers
  logic [LIMIT_W-1:0] similarity_limit;
  logic [LIMIT_W-1:0] drift_limit;

  // Input skid buffer
  logic               skid_full;
  logic [IN_W-1:0]    skid_data;
  logic               in_accept;
  logic               front_valid;
  logic [IN_W-1:0]    front_data;
  snav_pixel_t        front_center;
  logic [SUM_W-1:0]   front_center_sum;

  // Pipeline control: every stage moves together when the output can load
  logic               advance;
  logic               a_valid;
  logic               b_valid;
  logic               c_valid;
  logic               d_valid;
  logic               out_valid;

  // Payload pipe
  snav_lane_t         lanes [NB_COUNT];
  snav_pixel_t        center_a;
  snav_pixel_t        center_b;
  snav_pixel_t        center_c;
  snav_pixel_t        center_d;
  logic [TOTAL_W-1:0] total_red;
  logic [TOTAL_W-1:0] total_green;
  logic [TOTAL_W-1:0] total_blue;
  logic [CNT_W-1:0]   count_b;
  logic [CNT_W-1:0]   count_c;
  logic [CNT_W-1:0]   count_d;
  snav_pixel_t        filtered;
  logic [SUM_W-1:0]   change;
  logic               moved_far;
  logic [OUT_W-1:0]   out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      similarity_limit <= LIMIT_W'(SIM_RESET);
      drift_limit      <= LIMIT_W'(DRIFT_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIMILARITY: similarity_limit <= cfg_data;
        REG_DRIFT:      drift_limit      <= cfg_data;
        default: ;      // drop writes beyond the register list
      endcase
    end
  end

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !skid_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Park a request that arrives while the pipe is held; drain it first
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (in_accept && !advance) begin
      skid_full <= 1'b1;
    end else if (advance) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && !advance) begin
      skid_data <= s_axis_tdata;
    end
  end

  assign front_valid      = skid_full || in_accept;
  assign front_data       = skid_full ? skid_data : s_axis_tdata;
  assign front_center     = front_data[PIX_W-1:0];
  assign front_center_sum = chan_sum(front_center);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= front_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      out_valid <= d_valid;
    end
  end

  // Stage A: one lane per neighbor decides whether it joins
  for (genvar k = 0; k < NB_COUNT; k++) begin : g_lane
    snav_lane u_lane (
      .clk        (clk),
      .en         (advance),
      .center_sum (front_center_sum),
      .pixel      (front_data[PIX_W*(k+1) +: PIX_W]),
      .present    (front_data[PRESENT_LSB + k]),
      .limit      (similarity_limit),
      .lane       (lanes[k])
    );
  end

  // Stage B: add up the joined pixels and count them
  snav_merge u_merge (
    .clk         (clk),
    .en          (advance),
    .center      (center_a),
    .lanes       (lanes),
    .total_red   (total_red),
    .total_green (total_green),
    .total_blue  (total_blue),
    .count       (count_b)
  );

  // Stages C and D: divide each channel total by the count, with rounding
  snav_div u_div_red (
    .clk    (clk),
    .en     (advance),
    .total  (total_red),
    .count  (count_b),
    .result (filtered.red)
  );

  snav_div u_div_green (
    .clk    (clk),
    .en     (advance),
    .total  (total_green),
    .count  (count_b),
    .result (filtered.green)
  );

  snav_div u_div_blue (
    .clk    (clk),
    .en     (advance),
    .total  (total_blue),
    .count  (count_b),
    .result (filtered.blue)
  );

  // Carry the center and the count alongside the arithmetic
  always_ff @(posedge clk) begin
    if (advance) begin
      center_a <= front_center;
      center_b <= center_a;
      center_c <= center_b;
      center_d <= center_c;
      count_c  <= count_b;
      count_d  <= count_c;
    end
  end

  // Stage E: how far the center moved, then load the output register
  always_comb begin
    change =
      SUM_W'((center_d.red   >= filtered.red)   ? center_d.red   - filtered.red
                                                : filtered.red   - center_d.red) +
      SUM_W'((center_d.green >= filtered.green) ? center_d.green - filtered.green
                                                : filtered.green - center_d.green) +
      SUM_W'((center_d.blue  >= filtered.blue)  ? center_d.blue  - filtered.blue
                                                : filtered.blue  - center_d.blue);
    moved_far = change > drift_limit;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {OUT_PAD_W'(0), moved_far, count_d, filtered};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ===== sv/snav_lane.sv =====
module snav_lane import snav_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SUM_W-1:0]   center_sum,
  input  snav_pixel_t        pixel,
  input  logic               present,
  input  logic [LIMIT_W-1:0] limit,
  output snav_lane_t         lane
);

  logic [SUM_W-1:0] psum;
  logic [SUM_W-1:0] diff;
  logic             join_en;

  always_comb begin
    psum    = chan_sum(pixel);
    diff    = (center_sum >= psum) ? center_sum - psum : psum - center_sum;
    join_en = present && (diff < limit);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane.join_en <= join_en;
      lane.red     <= join_en ? pixel.red   : '0;
      lane.green   <= join_en ? pixel.green : '0;
      lane.blue    <= join_en ? pixel.blue  : '0;
    end
  end

endmodule

// ===== sv/snav_merge.sv =====
module snav_merge import snav_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  snav_pixel_t        center,
  input  snav_lane_t         lanes [NB_COUNT],
  output logic [TOTAL_W-1:0] total_red,
  output logic [TOTAL_W-1:0] total_green,
  output logic [TOTAL_W-1:0] total_blue,
  output logic [CNT_W-1:0]   count
);

  logic [TOTAL_W-1:0] sum_red;
  logic [TOTAL_W-1:0] sum_green;
  logic [TOTAL_W-1:0] sum_blue;
  logic [CNT_W-1:0]   sum_count;

  // Center always joins
  always_comb begin
    sum_red   = TOTAL_W'(center.red);
    sum_green = TOTAL_W'(center.green);
    sum_blue  = TOTAL_W'(center.blue);
    sum_count = CNT_W'(1);
    for (int k = 0; k < NB_COUNT; k++) begin
      sum_red   = sum_red   + TOTAL_W'(lanes[k].red);
      sum_green = sum_green + TOTAL_W'(lanes[k].green);
      sum_blue  = sum_blue  + TOTAL_W'(lanes[k].blue);
      sum_count = sum_count + CNT_W'(lanes[k].join_en);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total_red   <= sum_red;
      total_green <= sum_green;
      total_blue  <= sum_blue;
      count       <= sum_count;
    end
  end

endmodule

// ===== sv/snav_div.sv =====
module snav_div import snav_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [TOTAL_W-1:0] total,
  input  logic [CNT_W-1:0]   count,
  output logic [CHAN_W-1:0]  result
);

  logic [TOTAL_W+RECIP_W-1:0] prod;
  logic [CHAN_W-1:0]          q0;
  logic [TOTAL_W-1:0]         total_c;
  logic [CNT_W-1:0]           count_c;

  logic [TOTAL_W-1:0]         back;
  logic [TOTAL_W-1:0]         rem0;
  logic [CHAN_W-1:0]          quo;
  logic [CNT_W-1:0]           rem;
  logic [CHAN_W:0]            q_plus_r;
  logic [CHAN_W-1:0]          rounded;

  // Estimate: never above the true quotient, at most one below
  assign prod = (TOTAL_W + RECIP_W)'(total) * (TOTAL_W + RECIP_W)'(recip(count));

  always_ff @(posedge clk) begin
    if (en) begin
      q0      <= prod[RECIP_SHIFT +: CHAN_W];
      total_c <= total;
      count_c <= count;
    end
  end

  // Fix up the estimate, then add the remainder parity unless near full scale
  always_comb begin
    back = TOTAL_W'(q0) * TOTAL_W'(count_c);
    rem0 = total_c - back;
    if (rem0 >= TOTAL_W'(count_c)) begin
      quo = q0 + CHAN_W'(1);
      rem = CNT_W'(rem0 - TOTAL_W'(count_c));
    end else begin
      quo = q0;
      rem = CNT_W'(rem0);
    end
    q_plus_r = (CHAN_W + 1)'(quo) + (CHAN_W + 1)'(rem);
    if (q_plus_r < (CHAN_W + 1)'(FULL_SCALE)) begin
      rounded = quo + CHAN_W'(rem[0]);
    end else begin
      rounded = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= rounded;
    end
  end

endmodule

// ===== sv/snav_checker.sv =====
module snav_checker import snav_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_W-1:0]     m_axis_tdata
);

  // No result may show up straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Joined count stays within center-only to all nine, padding stays zero
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tdata[OUT_MOVED_BIT-1:OUT_COUNT_LSB] != CNT_W'(0) &&
      m_axis_tdata[OUT_MOVED_BIT-1:OUT_COUNT_LSB] <= CNT_W'(MAX_JOINED) &&
      m_axis_tdata[OUT_W-1:OUT_MOVED_BIT+1] == OUT_PAD_W'(0))
    else $error("joined count out of range or padding set");

  // A center averaged with nobody cannot have moved
  a_lone_center: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_MOVED_BIT-1:OUT_COUNT_LSB] == CNT_W'(1) |->
      !m_axis_tdata[OUT_MOVED_BIT])
    else $error("lone center flagged as moved");

  // Input backpressure only follows a request taken while the output stalled
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |->
      $past(s_axis_tvalid && m_axis_tvalid && !m_axis_tready))
    else $error("input ready dropped without an output stall");

endmodule

bind selective_neighbor_average_3x3_unit snav_checker u_snav_checker (.*);
